FILE: design/hsb_to_rgb_defines.svh
// Assertion macros for the hsb_to_rgb design.
`ifndef HSB_TO_RGB_DEFINES_SVH
`define HSB_TO_RGB_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication: cons must hold once the delay set by lat has passed after ante.
`define HSB_ASSERT_LAT(label, clk, rst_n, ante, lat, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
        else $error(msg);

`endif

FILE: design/hsb_pkg.sv
package hsb_pkg;

    // Fixed port widths
    localparam int HUE_W = 24;
    localparam int SB_W  = 18;
    localparam int OUT_W = 17;

    // Hue sector codes (one sixth of a turn each)
    localparam logic [2:0] SECT_RED_YEL = 3'd0;
    localparam logic [2:0] SECT_YEL_GRN = 3'd1;
    localparam logic [2:0] SECT_GRN_CYN = 3'd2;
    localparam logic [2:0] SECT_CYN_BLU = 3'd3;
    localparam logic [2:0] SECT_BLU_MAG = 3'd4;
    localparam logic [2:0] SECT_MAG_RED = 3'd5;

    typedef logic [2:0] sector_t;

endpackage

FILE: design/hsb_to_rgb.sv
// Channel   | Ports                              | Handshake
// ----------+------------------------------------+-----------------------------
// command   | hue_in, sat_in, bright_in          | start && !busy takes a beat
// result    | red_out, green_out, blue_out       | done marks a one-cycle beat
//
// Throughput: one beat per clock; busy is never raised.
// Pipeline: registered stages from the accepting edge to done (clamp/sector, three
//   products, second products, sector select), one multiplier deep per stage.
// Reset: rst_n clears the stage valid bits only; data registers are not reset.
// Stalls: none; results leave the output register without back pressure.
`include "hsb_to_rgb_defines.svh"

module hsb_to_rgb
    import hsb_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [HUE_W-1:0] hue_in,
    input  logic signed [SB_W-1:0]  sat_in,
    input  logic signed [SB_W-1:0]  bright_in,
    output logic                    done,
    output logic [OUT_W-1:0]        red_out,
    output logic [OUT_W-1:0]        green_out,
    output logic [OUT_W-1:0]        blue_out
);

    localparam int FB = FRAC_BITS;
    localparam int PW = 2 * FB + 2;                        // product width
    localparam int CW = (SB_W > FB + 1) ? SB_W + 1 : FB + 2; // clamp compare width

    localparam logic [FB:0]   ONE   = {1'b1, {FB{1'b0}}};
    localparam logic [CW-1:0] ONE_C = {{(CW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

    // Pipeline never stalls, so the command side is always open.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // ---------------- Stage 1: clamp s/b, split hue into sector and fraction
    logic signed [CW-1:0] sat_x, bright_x;
    logic [FB:0]          s_next, b_next;
    logic [FB+2:0]        hd;
    sector_t              sect_next;
    logic [FB-1:0]        f_next;

    assign sat_x    = CW'(sat_in);
    assign bright_x = CW'(bright_in);

    always_comb
    begin
        priority if (sat_x[CW-1])
            s_next = '0;
        else if (sat_x > $signed(ONE_C))
            s_next = ONE;
        else
            s_next = sat_x[FB:0];

        priority if (bright_x[CW-1])
            b_next = '0;
        else if (bright_x > $signed(ONE_C))
            b_next = ONE;
        else
            b_next = bright_x[FB:0];
    end

    // Only the fraction of a turn matters; the low bits are the floor wrap.
    assign hd        = (FB+3)'(hue_in[FB-1:0]) * (FB+3)'(6);
    assign sect_next = hd[FB+2:FB];
    assign f_next    = hd[FB-1:0];

    logic          v1_reg;
    logic [FB:0]   s1_reg, b1_reg;
    sector_t       sect1_reg;
    logic [FB-1:0] f1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s_next;
        b1_reg    <= b_next;
        sect1_reg <= sect_next;
        f1_reg    <= f_next;
    end

    // ---------------- Stage 2: b*(1-s), s*f, s*(1-f) in parallel
    logic [PW-1:0] pp_next, sf_next, sg_next;
    logic [FB:0]   om_f;

    assign om_f    = ONE - {1'b0, f1_reg};
    assign pp_next = PW'(b1_reg) * PW'(ONE - s1_reg);
    assign sf_next = PW'(s1_reg) * PW'(f1_reg);
    assign sg_next = PW'(s1_reg) * PW'(om_f);

    logic          v2_reg;
    logic [FB:0]   b2_reg;
    sector_t       sect2_reg;
    logic [PW-1:0] pp2_reg, sf2_reg, sg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        b2_reg    <= b1_reg;
        sect2_reg <= sect1_reg;
        pp2_reg   <= pp_next;
        sf2_reg   <= sf_next;
        sg2_reg   <= sg_next;
    end

    // ---------------- Stage 3: q and t products, p is final here
    // s*f and s*(1-f) never exceed 1.0 after the shift, so FB+1 bits hold them.
    logic [PW-1:0] qp_next, tp_next;

    assign qp_next = PW'(b2_reg) * PW'(ONE - sf2_reg[2*FB:FB]);
    assign tp_next = PW'(b2_reg) * PW'(ONE - sg2_reg[2*FB:FB]);

    logic          v3_reg;
    logic [FB:0]   b3_reg, p3_reg;
    sector_t       sect3_reg;
    logic [PW-1:0] qp3_reg, tp3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        b3_reg    <= b2_reg;
        p3_reg    <= pp2_reg[2*FB:FB];
        sect3_reg <= sect2_reg;
        qp3_reg   <= qp_next;
        tp3_reg   <= tp_next;
    end

    // ---------------- Stage 4: sector select into the output register
    // Black and grey need no special path: b=0 zeroes p/q/t, s=0 makes them b.
    logic [FB:0]      q3, t3;
    logic [FB:0]      r_sel, g_sel, bl_sel;

    assign q3 = qp3_reg[2*FB:FB];
    assign t3 = tp3_reg[2*FB:FB];

    always_comb
    begin
        unique case (sect3_reg)
            SECT_RED_YEL: begin r_sel = b3_reg; g_sel = t3;     bl_sel = p3_reg; end
            SECT_YEL_GRN: begin r_sel = q3;     g_sel = b3_reg; bl_sel = p3_reg; end
            SECT_GRN_CYN: begin r_sel = p3_reg; g_sel = b3_reg; bl_sel = t3;     end
            SECT_CYN_BLU: begin r_sel = p3_reg; g_sel = q3;     bl_sel = b3_reg; end
            SECT_BLU_MAG: begin r_sel = t3;     g_sel = p3_reg; bl_sel = b3_reg; end
            default:      begin r_sel = b3_reg; g_sel = p3_reg; bl_sel = q3;     end
        endcase
    end

    logic             done_reg;
    logic [OUT_W-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= OUT_W'(r_sel);
        green_reg <= OUT_W'(g_sel);
        blue_reg  <= OUT_W'(bl_sel);
    end

    assign done      = done_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    // ---------------- Checks
    `HSB_ASSERT_LAT(a_lat_fwd, clk, rst_n, accept, 4, done, "accepted beat produced no result")
    `HSB_ASSERT_NOW(a_lat_back, clk, rst_n, done, $past(accept, 4), "result without a command beat")
    `HSB_ASSERT_NOW(a_sector, clk, rst_n, v2_reg, sect2_reg <= SECT_MAG_RED, "hue sector out of range")

endmodule

FILE: sim/hsb_to_rgb_tb.sv
`timescale 1ns / 100ps

// Color space converter bench: hue/saturation/brightness in, red/green/blue out.
// The sender changes inputs on the falling edge. Results are checked against an
// in-bench predictor on the rising edge at which done is high.
module hsb_to_rgb_tb;

    import hsb_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam longint unsigned UNIT = longint'(1) << FRAC_BITS;
    // Pipeline is 4 deep; give the tail a comfortable margin.
    localparam int DRAIN_LIMIT = 64;
    localparam int TAIL_CYCLES = 12;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [HUE_W-1:0] hue_in;
    logic signed [SB_W-1:0]  sat_in;
    logic signed [SB_W-1:0]  bright_in;
    logic                    done;
    logic [OUT_W-1:0]        red_out;
    logic [OUT_W-1:0]        green_out;
    logic [OUT_W-1:0]        blue_out;

    // Expected colors, oldest first; one entry per accepted beat.
    rgb_t expected_rgb_q[$];
    int   error_count = 0;

    hsb_to_rgb #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .hue_in    (hue_in),
        .sat_in    (sat_in),
        .bright_in (bright_in),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block never answers.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Saturate a signed Q.16 value to 0..1.0.
    function automatic longint unsigned clamp_unit(logic signed [SB_W-1:0] v);
        longint sv;
        sv = v;
        if (sv < 0)
            return 0;
        if (sv > longint'(UNIT))
            return UNIT;
        return longint'(sv);
    endfunction

    // Six-sector conversion, all products truncated.
    function automatic rgb_t predict_rgb(logic [HUE_W-1:0] hue,
                                         logic signed [SB_W-1:0] sat,
                                         logic signed [SB_W-1:0] bright);
        longint unsigned h, s, b, hd, f, p, q, t;
        longint unsigned r, g, bl;
        sector_t         sect;
        rgb_t            res;
        // Only the fraction of a turn matters; the two's complement low bits
        // already give the floor wrap for negative hues.
        h = longint'(hue) & (UNIT - 1);
        s = clamp_unit(sat);
        b = clamp_unit(bright);
        if (b == 0)
        begin
            r = 0;
            g = 0;
            bl = 0;
        end
        else if (s == 0)
        begin
            r = b;
            g = b;
            bl = b;
        end
        else
        begin
            hd   = h * 6;
            sect = sector_t'(hd >> FRAC_BITS);
            f    = hd & (UNIT - 1);
            p    = (b * (UNIT - s)) >> FRAC_BITS;
            q    = (b * (UNIT - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
            t    = (b * (UNIT - ((s * (UNIT - f)) >> FRAC_BITS))) >> FRAC_BITS;
            case (sect)
                SECT_RED_YEL: begin r = b; g = t; bl = p; end
                SECT_YEL_GRN: begin r = q; g = b; bl = p; end
                SECT_GRN_CYN: begin r = p; g = b; bl = t; end
                SECT_CYN_BLU: begin r = p; g = q; bl = b; end
                SECT_BLU_MAG: begin r = t; g = p; bl = b; end
                default:      begin r = b; g = p; bl = q; end
            endcase
        end
        res.red   = OUT_W'(r);
        res.green = OUT_W'(g);
        res.blue  = OUT_W'(bl);
        return res;
    endfunction

    //------------------------------------------------------------------
    // Reporting and result checking
    //------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (error_count < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    // done marks each result beat and cannot be held off, so every rising edge
    // with done high is a result beat.
    always @(posedge clk)
    begin
        rgb_t exp_rgb;
        if (rst_n && done)
        begin
            if (expected_rgb_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                          red_out, green_out, blue_out));
            end
            else
            begin
                exp_rgb = expected_rgb_q.pop_front();
                if (red_out !== exp_rgb.red)
                    report_mismatch($sformatf("red got %0d want %0d",
                                              red_out, exp_rgb.red));
                if (green_out !== exp_rgb.green)
                    report_mismatch($sformatf("green got %0d want %0d",
                                              green_out, exp_rgb.green));
                if (blue_out !== exp_rgb.blue)
                    report_mismatch($sformatf("blue got %0d want %0d",
                                              blue_out, exp_rgb.blue));
            end
        end
    end

    //------------------------------------------------------------------
    // Sender
    //------------------------------------------------------------------

    // One command beat. start stays high on return; the next call or an idle
    // cycle decides its value at the following falling edge.
    task automatic send_beat(input int hue, input int sat, input int bright);
        logic [HUE_W-1:0] h;
        logic [SB_W-1:0]  s;
        logic [SB_W-1:0]  b;
        h = HUE_W'(hue);
        s = SB_W'(sat);
        b = SB_W'(bright);
        @(negedge clk);
        start     <= 1'b1;
        hue_in    <= h;
        sat_in    <= s;
        bright_in <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_rgb_q.push_back(predict_rgb(h, s, b));
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Random gap: each cycle idles with probability pct percent.
    task automatic idle_gap(input int pct);
        while ($urandom_range(0, 99) < pct)
            idle_cycle();
    endtask

    // Saturation/brightness: mostly legal levels, plus the clamp regions.
    function automatic int rand_level();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return int'(UNIT);
            2:       return -$urandom_range(1, 131072);
            3:       return $urandom_range(65537, 131071);
            4, 5:    return int'($urandom() & 32'h3FFFF);
            6:       return $urandom_range(1, 16);
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    // Hue: mostly full-range, some near sector edges and whole turns.
    function automatic int rand_hue();
        int k;
        case ($urandom_range(0, 7))
            0:
            begin
                k = $urandom_range(0, 6);
                return (k * 65536) / 6 + $urandom_range(0, 4) - 2
                       + int'($urandom_range(0, 255)) * 65536 - 128 * 65536;
            end
            1:       return (int'($urandom_range(0, 255)) - 128) * 65536;
            default: return int'($urandom() & 32'hFFFFFF);
        endcase
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Field extremes and clamping.
    task automatic test_extremes();
        send_beat(0, 65536, 65536);
        send_beat(8388607, 131071, 131071);
        send_beat(-8388608, -131072, 131071);
        send_beat(-1, 65536, 1);
        send_beat(65535, 1, 65536);
        send_beat(12345, 131071, -1);
    endtask

    // Black, grey, and hue wrap.
    task automatic test_special_cases();
        send_beat(20000, 65536, 0);          // black, full saturation
        send_beat(20000, 0, 0);              // black wins over grey
        send_beat(30000, 40000, -131072);    // negative brightness clamps to black
        send_beat(30000, 0, 40000);          // grey
        send_beat(30000, -131072, 65536);    // negative saturation clamps to grey
        send_beat(65536, 50000, 50000);      // one whole turn
        send_beat(-3 * 65536, 50000, 50000); // negative whole turns
        send_beat(-10000, 50000, 50000);     // negative fraction wraps up
    endtask

    // Each sector once, plus the edge just past a boundary.
    task automatic test_sectors();
        for (int k = 0; k < 6; k++)
            send_beat((k * 65536) / 6 + 1000, 60000, 60000);
        send_beat(10923, 65536, 65536);      // lands 2 past the sector 1 edge
        send_beat(10922, 65536, 65536);      // last step of sector 0
    endtask

    task automatic test_random_beats(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
        begin
            idle_gap(idle_pct);
            send_beat(rand_hue(), rand_level(), rand_level());
        end
    endtask

    // Sender holds off until the pipeline is empty, then resumes back to back.
    task automatic test_drain_pause();
        test_random_beats(10, 0);
        idle_cycle();
        while (expected_rgb_q.size() != 0)
            idle_cycle();
        test_random_beats(10, 0);
    endtask

    task automatic wait_for_drain();
        int n;
        idle_cycle();
        n = 0;
        while (expected_rgb_q.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (TAIL_CYCLES)
            @(posedge clk);
        while (expected_rgb_q.size() != 0)
        begin
            void'(expected_rgb_q.pop_front());
            report_mismatch("expected result never arrived");
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        hue_in    = '0;
        sat_in    = '0;
        bright_in = '0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_special_cases();
        test_sectors();

        // No idling, then sender idle about half the time, a drain pause, then light idling.
        test_random_beats(160, 0);
        test_random_beats(160, 49);
        test_drain_pause();
        test_random_beats(160, 15);

        wait_for_drain();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: hsb_to_rgb.f
+incdir+design
design/hsb_pkg.sv
design/hsb_to_rgb.sv
sim/hsb_to_rgb_tb.sv
